/* hw/rtl/tsvf_pkg.sv */
`default_nettype none

package tsvf_pkg;

	// Default widths of samples and integrator states
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int STATE_BITS_DEF  = 40;

	// Coefficient formats: gains Q2.22, damping Q10.20
	localparam int COEF_W = 24;
	localparam int DAMP_W = 30;

	// Multiplier coefficient word: gains zero-extended, damping shifted up by two so
	// that every product shares one binary point
	localparam int MUL_COEF_W = 32;
	localparam int MUL_FRAC   = 22;
	localparam int DAMP_SHIFT = 2;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = DAMP_W;

	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_A = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_B = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_C = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DAMP   = 3'd4;

	// Register values after reset
	localparam logic [COEF_W-1:0] RST_GAIN_A = 24'd127389;
	localparam logic [COEF_W-1:0] RST_GAIN_B = 24'd262764;
	localparam logic [COEF_W-1:0] RST_GAIN_C = 24'd3994;
	localparam logic [COEF_W-1:0] RST_GAIN_D = 24'd254778;
	localparam logic [DAMP_W-1:0] RST_DAMP   = 30'd1048576;

	typedef struct packed {
		logic [COEF_W-1:0] gain_a;
		logic [COEF_W-1:0] gain_b;
		logic [COEF_W-1:0] gain_c;
		logic [COEF_W-1:0] gain_d;
		logic [DAMP_W-1:0] damp;
	} coef_set_t;

endpackage

`default_nettype wire

/* hw/rtl/tsvf_cfg_regs.sv */
`default_nettype none

module tsvf_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tsvf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [tsvf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output tsvf_pkg::coef_set_t                    coefs
);

	tsvf_pkg::coef_set_t coefs_q;

	// Decode writes; unknown indices are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.gain_a <= tsvf_pkg::RST_GAIN_A;
			coefs_q.gain_b <= tsvf_pkg::RST_GAIN_B;
			coefs_q.gain_c <= tsvf_pkg::RST_GAIN_C;
			coefs_q.gain_d <= tsvf_pkg::RST_GAIN_D;
			coefs_q.damp   <= tsvf_pkg::RST_DAMP;
		end else if (cfg_we) begin
			case (cfg_addr)
				tsvf_pkg::REG_GAIN_A: coefs_q.gain_a <= cfg_wdata[tsvf_pkg::COEF_W-1:0];
				tsvf_pkg::REG_GAIN_B: coefs_q.gain_b <= cfg_wdata[tsvf_pkg::COEF_W-1:0];
				tsvf_pkg::REG_GAIN_C: coefs_q.gain_c <= cfg_wdata[tsvf_pkg::COEF_W-1:0];
				tsvf_pkg::REG_GAIN_D: coefs_q.gain_d <= cfg_wdata[tsvf_pkg::COEF_W-1:0];
				tsvf_pkg::REG_DAMP:   coefs_q.damp   <= cfg_wdata[tsvf_pkg::DAMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

`default_nettype wire

/* hw/rtl/tsvf_sat.sv */
`default_nettype none

module tsvf_sat #(
	parameter int IN_W  = 42,
	parameter int OUT_W = 24
) (
	input  wire logic signed [IN_W-1:0]  din,
	output logic signed [OUT_W-1:0]      dout,
	output logic                         clip
);

	logic [IN_W-OUT_W:0] top_bits;
	logic                fits;

	// The value fits when every bit from the output sign upwards agrees
	assign top_bits = din[IN_W-1:OUT_W-1];
	assign fits     = (&top_bits) | ~(|top_bits);
	assign clip     = ~fits;

	// Clamp to the extreme on the side of the sign
	always_comb begin
		if (fits) begin
			dout = din[OUT_W-1:0];
		end else if (din[IN_W-1]) begin
			dout = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			dout = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tsvf_serial_mul.sv */
`default_nettype none

// Bit-serial sign-magnitude multiplier: one coefficient bit per cycle, LSB first,
// product rounded half away from zero at MUL_FRAC fractional bits.
module tsvf_serial_mul #(
	parameter int OPW = 42,
	localparam int CW    = tsvf_pkg::MUL_COEF_W,
	localparam int FRAC  = tsvf_pkg::MUL_FRAC,
	localparam int RW    = OPW + CW - FRAC + 2,
	localparam int CNT_W = $clog2(CW)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [CW-1:0]         coef,
	input  wire logic signed [OPW-1:0] operand,
	output logic                       done,
	output logic signed [RW-1:0]       result
);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CW-1:0]     coef_q;
	logic [OPW-1:0]    mag_q;
	logic              neg_q;
	logic [OPW-1:0]    acc_q;
	logic [CW-1:0]     low_q;
	logic signed [RW-1:0] result_q;

	logic [OPW:0]          sum;
	logic [OPW+CW-FRAC-1:0] quot;
	logic [RW-1:0]         quot_ext;
	logic                  rnd_bit;

	// Partial product for the current coefficient bit
	assign sum = {1'b0, acc_q} + (coef_q[0] ? {1'b0, mag_q} : {(OPW+1){1'b0}});

	// Truncated quotient and the bit below the binary point
	assign quot     = {acc_q, low_q[CW-1:FRAC]};
	assign quot_ext = {2'b00, quot};
	assign rnd_bit  = low_q[FRAC-1];

	// Control: load, iterate over the coefficient bits, round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: shift the coefficient out, shift product bits into the low word
	always_ff @(posedge clk) begin
		if (start) begin
			coef_q <= coef;
			neg_q  <= operand[OPW-1];
			mag_q  <= operand[OPW-1] ? (~operand + 1'b1) : operand;
			acc_q  <= '0;
			low_q  <= '0;
		end else if (busy_q) begin
			coef_q <= {1'b0, coef_q[CW-1:1]};
			acc_q  <= sum[OPW:1];
			low_q  <= {sum[0], low_q[CW-1:1]};
		end else if (fin_q) begin
			// Round on the magnitude, then restore the sign in the same add
			if (neg_q) begin
				result_q <= ~quot_ext + {{(RW-1){1'b0}}, ~rnd_bit};
			end else begin
				result_q <= quot_ext + {{(RW-1){1'b0}}, rnd_bit};
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !fin_q))
		else $error("multiplier started while busy");

	a_done_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(fin_q))
		else $error("multiplier done without rounding step");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && fin_q))
		else $error("multiplier iterating and rounding at once");

endmodule

`default_nettype wire

/* hw/rtl/trapezoidal_state_variable_filter_top.sv */
`default_nettype none

// Channel   Direction  Payload (lowest bits first)
// s_axis    in         sample_in
// m_axis    out        lowpass_out, highpass_out, bandpass_out, notch_out, clipped
// cfg       in         write enable, register index, data (gains 0..3, damping 4)
//
// Each sample needs five products, run one after another through a
// single bit-serial multiplier, 32 coefficient bits plus load and rounding each.
// A new sample is taken only when the previous one has left the sequencer; a result
// waits in the output register, and the next sample can run meanwhile.
// Reset clears the integrator states and the previous input, and loads the register
// defaults.
module trapezoidal_state_variable_filter_top #(
	parameter int SAMPLE_BITS = tsvf_pkg::SAMPLE_BITS_DEF,
	parameter int STATE_BITS  = tsvf_pkg::STATE_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((4 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [IN_W-1:0]                 s_axis_tdata,  // sample_in
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// lowpass_out, highpass_out, bandpass_out, notch_out, clipped
	output logic [OUT_W-1:0]                     m_axis_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [tsvf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [tsvf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SB   = SAMPLE_BITS;
	localparam int STB  = STATE_BITS;
	localparam int MW   = STB + 2;
	localparam int CW   = tsvf_pkg::MUL_COEF_W;
	localparam int RW   = MW + CW - tsvf_pkg::MUL_FRAC + 2;
	localparam int ACW  = RW + 2;
	localparam int PADW = OUT_W - (4 * SB + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_V3    = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_SAT   = 3'd4;
	localparam logic [2:0] S_HP    = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	localparam logic [2:0] OP_A = 3'd0;
	localparam logic [2:0] OP_B = 3'd1;
	localparam logic [2:0] OP_C = 3'd2;
	localparam logic [2:0] OP_D = 3'd3;
	localparam logic [2:0] OP_K = 3'd4;

	tsvf_pkg::coef_set_t coefs;

	logic [2:0] state_q;
	logic [2:0] op_q;

	logic signed [SB-1:0]  v0_q;
	logic signed [SB-1:0]  prev_q;
	logic signed [SB:0]    pair_q;
	logic signed [MW-1:0]  v3_q;
	logic signed [STB-1:0] band_q;
	logic signed [STB-1:0] low_q;
	logic signed [ACW-1:0] acc1_q;
	logic signed [ACW-1:0] acc2_q;
	logic signed [ACW-1:0] nt_q;
	logic signed [ACW-1:0] hp_q;
	logic                  clip_q;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic                  mul_start;
	logic [CW-1:0]         mul_coef;
	logic signed [MW-1:0]  mul_opnd;
	logic                  mul_done;
	logic signed [RW-1:0]  mul_res;
	logic signed [ACW-1:0] mul_res_ext;
	logic signed [ACW-1:0] band_ext;
	logic signed [ACW-1:0] low_ext;
	logic signed [ACW-1:0] v0_ext;
	logic signed [MW-1:0]  band_mw;

	logic signed [STB-1:0] band_sat;
	logic signed [STB-1:0] low_sat;
	logic                  band_clip;
	logic                  low_clip;
	logic signed [SB-1:0]  lp_o;
	logic signed [SB-1:0]  hp_o;
	logic signed [SB-1:0]  bp_o;
	logic signed [SB-1:0]  nt_o;
	logic                  lp_clip;
	logic                  hp_clip;
	logic                  bp_clip;
	logic                  nt_clip;
	logic                  in_acc;
	logic                  out_free;

	tsvf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.coefs     (coefs)
	);

	tsvf_serial_mul #(.OPW(MW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.coef    (mul_coef),
		.operand (mul_opnd),
		.done    (mul_done),
		.result  (mul_res)
	);

	// Saturate the new states and the four responses
	tsvf_sat #(.IN_W(ACW), .OUT_W(STB)) u_sat_band (
		.din(acc1_q), .dout(band_sat), .clip(band_clip));
	tsvf_sat #(.IN_W(ACW), .OUT_W(STB)) u_sat_low (
		.din(acc2_q), .dout(low_sat), .clip(low_clip));
	tsvf_sat #(.IN_W(STB), .OUT_W(SB)) u_sat_lp (
		.din(low_q), .dout(lp_o), .clip(lp_clip));
	tsvf_sat #(.IN_W(ACW), .OUT_W(SB)) u_sat_hp (
		.din(hp_q), .dout(hp_o), .clip(hp_clip));
	tsvf_sat #(.IN_W(STB), .OUT_W(SB)) u_sat_bp (
		.din(band_q), .dout(bp_o), .clip(bp_clip));
	tsvf_sat #(.IN_W(ACW), .OUT_W(SB)) u_sat_nt (
		.din(nt_q), .dout(nt_o), .clip(nt_clip));

	// Sign extensions onto the accumulator width
	assign mul_res_ext = {{(ACW-RW){mul_res[RW-1]}}, mul_res};
	assign band_ext    = {{(ACW-STB){band_q[STB-1]}}, band_q};
	assign low_ext     = {{(ACW-STB){low_q[STB-1]}}, low_q};
	assign v0_ext      = {{(ACW-SB){v0_q[SB-1]}}, v0_q};
	assign band_mw     = {{(MW-STB){band_q[STB-1]}}, band_q};

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Select coefficient and operand for the current product
	always_comb begin
		mul_start = (state_q == S_START);
		case (op_q)
			OP_A: begin
				mul_coef = {{(CW-tsvf_pkg::COEF_W){1'b0}}, coefs.gain_a};
				mul_opnd = v3_q;
			end
			OP_B: begin
				mul_coef = {{(CW-tsvf_pkg::COEF_W){1'b0}}, coefs.gain_b};
				mul_opnd = band_mw;
			end
			OP_C: begin
				mul_coef = {{(CW-tsvf_pkg::COEF_W){1'b0}}, coefs.gain_c};
				mul_opnd = v3_q;
			end
			OP_D: begin
				mul_coef = {{(CW-tsvf_pkg::COEF_W){1'b0}}, coefs.gain_d};
				mul_opnd = band_mw;
			end
			default: begin
				mul_coef = {coefs.damp, {tsvf_pkg::DAMP_SHIFT{1'b0}}};
				mul_opnd = band_mw;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_A;
			prev_q      <= '0;
			band_q      <= '0;
			low_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result when the output register is free; drop it once taken
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						prev_q  <= s_axis_tdata[SB-1:0];
						op_q    <= OP_A;
						state_q <= S_V3;
					end
				end
				S_V3: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mul_done) begin
						if (op_q == OP_D) begin
							state_q <= S_SAT;
						end else if (op_q == OP_K) begin
							state_q <= S_HP;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_START;
						end
					end
				end
				S_SAT: begin
					band_q  <= band_sat;
					low_q   <= low_sat;
					op_q    <= OP_K;
					state_q <= S_START;
				end
				S_HP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					v0_q   <= s_axis_tdata[SB-1:0];
					pair_q <= {s_axis_tdata[SB-1], s_axis_tdata[SB-1:0]}
						+ {prev_q[SB-1], prev_q};
				end
			end
			S_V3: begin
				v3_q <= {{(MW-SB-1){pair_q[SB]}}, pair_q}
					- {low_q[STB-1], low_q, 1'b0};
			end
			S_WAIT: begin
				if (mul_done) begin
					case (op_q)
						OP_A:    acc1_q <= band_ext + mul_res_ext;
						OP_B:    acc1_q <= acc1_q - mul_res_ext;
						OP_C:    acc2_q <= low_ext + mul_res_ext;
						OP_D:    acc2_q <= acc2_q + mul_res_ext;
						default: nt_q   <= v0_ext - mul_res_ext;
					endcase
				end
			end
			S_SAT: begin
				clip_q <= band_clip | low_clip;
			end
			S_HP: begin
				hp_q <= nt_q - low_ext;
			end
			S_OUT: begin
				if (out_free) begin
					out_data_q <= {{PADW{1'b0}},
						clip_q | lp_clip | hp_clip | bp_clip | nt_clip,
						nt_o, bp_o, hp_o, lp_o};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_V3))
		else $error("accepted sample did not start the sequence");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WAIT))
		else $error("product finished outside the wait state");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_q <= OP_K)
		else $error("product index out of range");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside the output state");

endmodule

`default_nettype wire

/* tb/svf_response_checker.sv */
`timescale 1ns / 1ps

// Watches the sample and response channels and the register port, keeps its own
// copy of the filter state and coefficients, and checks every response in order.
module svf_response_checker
	import tsvf_pkg::*;
#(
	parameter int SB       = SAMPLE_BITS_DEF,
	parameter int RESULT_W = ((4 * SAMPLE_BITS_DEF + 1 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [SB-1:0]         s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [RESULT_W-1:0]   m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int DAMP_FRAC = MUL_FRAC - DAMP_SHIFT;

	// Response word, lowest field in the lowest bits
	typedef struct packed {
		logic [RESULT_W-4*SB-2:0] pad;
		logic                     clipped;
		logic [SB-1:0]            notch;
		logic [SB-1:0]            band;
		logic [SB-1:0]            high;
		logic [SB-1:0]            low;
	} filter_out_t;

	coef_set_t   coefs;
	longint      band_st;
	longint      low_st;
	longint      prev_in;
	filter_out_t expected_responses[$];
	int          responses_seen;

	initial begin
		fail_count = 0;
		pending = 0;
		responses_seen = 0;
	end

	// coef * v / 2^frac, rounded half away from zero on the magnitude
	function automatic longint scale_round(input logic [31:0] coef, input longint v,
			input int frac);
		logic [127:0] wide;
		longint       mag_r;
		wide = (v < 0) ? 128'(-v) : 128'(v);
		wide = wide * coef;
		wide = (wide + (128'd1 << (frac - 1))) >> frac;
		mag_r = longint'(wide[63:0]);
		return (v < 0) ? -mag_r : mag_r;
	endfunction

	// Clamp to a signed width and flag the clip
	function automatic longint clamp_to(input longint v, input int bits, output bit hit);
		longint ceiling;
		ceiling = (longint'(1) << (bits - 1)) - 1;
		hit = (v > ceiling) || (v < -ceiling - 1);
		if (v > ceiling)
			return ceiling;
		if (v < -ceiling - 1)
			return -ceiling - 1;
		return v;
	endfunction

	// Advance both integrators by one sample and form the four responses
	function automatic filter_out_t advance_filter(input logic [SB-1:0] raw);
		filter_out_t r;
		longint      x, drive, band_nx, low_nx, notch_v, high_v, lim;
		bit          hit, clip;
		x = $signed(raw);
		drive = x + prev_in - 2 * low_st;
		band_nx = band_st + scale_round(coefs.gain_a, drive, MUL_FRAC)
			- scale_round(coefs.gain_b, band_st, MUL_FRAC);
		low_nx = low_st + scale_round(coefs.gain_c, drive, MUL_FRAC)
			+ scale_round(coefs.gain_d, band_st, MUL_FRAC);
		band_nx = clamp_to(band_nx, STATE_BITS_DEF, hit);
		clip = hit;
		low_nx = clamp_to(low_nx, STATE_BITS_DEF, hit);
		clip |= hit;
		band_st = band_nx;
		low_st = low_nx;
		prev_in = x;

		notch_v = x - scale_round(coefs.damp, band_nx, DAMP_FRAC);
		high_v = notch_v - low_nx;

		r = '0;
		lim = clamp_to(low_nx, SB, hit);
		clip |= hit;
		r.low = lim[SB-1:0];
		lim = clamp_to(high_v, SB, hit);
		clip |= hit;
		r.high = lim[SB-1:0];
		lim = clamp_to(band_nx, SB, hit);
		clip |= hit;
		r.band = lim[SB-1:0];
		lim = clamp_to(notch_v, SB, hit);
		clip |= hit;
		r.notch = lim[SB-1:0];
		r.clipped = clip;
		return r;
	endfunction

	task automatic check_field(input string label, input logic [SB-1:0] want,
			input logic [SB-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t response %0d: %s expected %h, got %h",
					$time, responses_seen, label, want, got);
		end
	endtask

	// Track register writes, predict each request, compare each response
	always @(posedge clk or negedge arst_n) begin
		filter_out_t got, want;
		if (!arst_n) begin
			coefs = '{gain_a: RST_GAIN_A, gain_b: RST_GAIN_B, gain_c: RST_GAIN_C,
				gain_d: RST_GAIN_D, damp: RST_DAMP};
			band_st = 0;
			low_st = 0;
			prev_in = 0;
			expected_responses.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_GAIN_A: coefs.gain_a = cfg_wdata[COEF_W-1:0];
					REG_GAIN_B: coefs.gain_b = cfg_wdata[COEF_W-1:0];
					REG_GAIN_C: coefs.gain_c = cfg_wdata[COEF_W-1:0];
					REG_GAIN_D: coefs.gain_d = cfg_wdata[COEF_W-1:0];
					REG_DAMP:   coefs.damp = cfg_wdata[DAMP_W-1:0];
					default:    ;
				endcase
			end

			if (s_tvalid && s_tready)
				expected_responses.push_back(advance_filter(s_tdata));

			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_responses.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected response %h", $time, m_tdata);
				end else begin
					want = expected_responses.pop_front();
					check_field("lowpass", want.low, got.low);
					check_field("highpass", want.high, got.high);
					check_field("bandpass", want.band, got.band);
					check_field("notch", want.notch, got.notch);
					check_field("clipped", SB'(want.clipped), SB'(got.clipped));
				end
				responses_seen++;
			end
		end
		pending = expected_responses.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import tsvf_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int RESULT_W    = ((4 * SB + 1 + 7) / 8) * 8;
	localparam int PAD_W       = CFG_DATA_W - COEF_W;
	localparam int HOLD_CYCLES = 2000;
	localparam int SEGMENTS    = 12;
	localparam int SEG_ITEMS   = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SB-1:0]         s_axis_tdata = '0;        // sample_in
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// lowpass_out, highpass_out, bandpass_out, notch_out, clipped
	logic [RESULT_W-1:0]   m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic                  hold_req = 1'b0;
	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	int                    fail_count;
	int                    pending;

	trapezoidal_state_variable_filter_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	svf_response_checker CHECK (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Give up well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Response side: random back-pressure, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Gain word with junk in the unused upper bits
	function automatic logic [CFG_DATA_W-1:0] gain_word(input logic [COEF_W-1:0] g);
		logic [PAD_W-1:0] junk;
		junk = PAD_W'($urandom);
		return {junk, g};
	endfunction

	// Write to every index past the last register; the block must ignore them
	task automatic poke_unused_regs();
		for (int r = int'(REG_DAMP) + 1; r < (1 << CFG_ADDR_W); r++)
			write_reg(CFG_ADDR_W'(r), CFG_DATA_W'($urandom));
	endtask

	task automatic write_setting(input coef_set_t cs);
		write_reg(REG_GAIN_A, gain_word(cs.gain_a));
		write_reg(REG_GAIN_B, gain_word(cs.gain_b));
		write_reg(REG_GAIN_C, gain_word(cs.gain_c));
		write_reg(REG_GAIN_D, gain_word(cs.gain_d));
		write_reg(REG_DAMP, cs.damp);
	endtask

	// Pick a coefficient set: tuned, wild, extreme or moderate
	task automatic apply_random_setting();
		coef_set_t cs;
		cs = '{gain_a: RST_GAIN_A, gain_b: RST_GAIN_B, gain_c: RST_GAIN_C,
			gain_d: RST_GAIN_D, damp: RST_DAMP};
		case ($urandom_range(3))
			0: cs.damp = DAMP_W'($urandom_range(2097152, 1049));
			1: begin
				cs.gain_a = COEF_W'($urandom);
				cs.gain_b = COEF_W'($urandom);
				cs.gain_c = COEF_W'($urandom);
				cs.gain_d = COEF_W'($urandom);
				cs.damp = DAMP_W'($urandom);
			end
			2: begin
				cs.gain_a = $urandom_range(1) ? '1 : '0;
				cs.gain_b = $urandom_range(1) ? '1 : '0;
				cs.gain_c = $urandom_range(1) ? '1 : '0;
				cs.gain_d = $urandom_range(1) ? '1 : '0;
				case ($urandom_range(3))
					0: cs.damp = '0;
					1: cs.damp = 30'd1049;
					2: cs.damp = 30'd1048576000;
					default: cs.damp = '1;
				endcase
			end
			default: begin
				cs.gain_a = COEF_W'($urandom_range(1048575));
				cs.gain_b = COEF_W'($urandom_range(1048575));
				cs.gain_c = COEF_W'($urandom_range(1048575));
				cs.gain_d = COEF_W'($urandom_range(1048575));
				cs.damp = DAMP_W'($urandom_range(1048576000, 1049));
			end
		endcase
		write_setting(cs);
		if ($urandom_range(3) == 0)
			poke_unused_regs();
	endtask

	function automatic logic [SB-1:0] random_sample();
		logic [SB-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: v = SB'($urandom);
			6, 7: v = SB'($urandom_range(8191)) - SB'(4096);
			8: v = $urandom_range(1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
			default: v = '0;
		endcase
		return v;
	endfunction

	// Offer one request, hold until taken, then maybe idle
	task automatic offer_sample(input logic [SB-1:0] x);
		s_axis_tdata <= x;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= SB'($urandom);
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Stop offering and wait for every outstanding response
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [SB-1:0] corner_samples [10];
		coef_set_t cs;

		corner_samples = '{24'h000000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			24'h800000, 24'hFFFFFF, 24'h000001, 24'hAAAAAA, 24'h555555};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner inputs with the values after reset
		foreach (corner_samples[i])
			offer_sample(corner_samples[i]);
		drain();

		// Every gain and the damping at full scale; drive the states into clamp
		poke_unused_regs();
		cs = '{gain_a: '1, gain_b: '1, gain_c: '1, gain_d: '1, damp: '1};
		write_setting(cs);
		for (int i = 0; i < 4; i++)
			offer_sample(i[0] ? 24'h800000 : 24'h7FFFFF);
		drain();

		// Zero gains and zero damping: states freeze, notch follows the input
		cs = '{gain_a: '0, gain_b: '0, gain_c: '0, gain_d: '0, damp: '0};
		write_setting(cs);
		offer_sample(24'h7FFFFF);
		offer_sample(24'h800000);
		offer_sample(24'h000123);
		drain();

		// Tuned gains at the damping range ends
		cs = '{gain_a: RST_GAIN_A, gain_b: RST_GAIN_B, gain_c: RST_GAIN_C,
			gain_d: RST_GAIN_D, damp: 30'd1049};
		write_setting(cs);
		offer_sample(24'h400000);
		offer_sample(24'hC00000);
		offer_sample(24'h000000);
		drain();
		write_reg(REG_DAMP, 30'd1048576000);
		offer_sample(24'h7FFFFF);
		offer_sample(24'h800000);
		offer_sample(24'h012345);

		// Random samples, new setting per segment, idling pattern changing by thirds
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			send_idle_pct = (seg < 4) ? 9 : (seg < 8) ? 85 : 0;
			recv_idle_pct = (seg < 4) ? 85 : (seg < 8) ? 9 : 0;
			apply_random_setting();
			if (seg == 2 || seg == 9)
				hold_req <= 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (seg == 5 && n == SEG_ITEMS / 2)
					drain();
				offer_sample(random_sample());
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
